// ===== src/sha256_pkg.sv =====
`default_nettype none

package sha256_pkg;

  // Eight 32-bit hash words; index 0 is the most significant digest word.
  typedef logic [7:0][31:0] hash_t;

  // Control from the byte sequencer to the compression unit.
  typedef struct packed {
    logic       start;      // begin 64 rounds on the loaded block
    logic       init;       // return the hash words to the initial values
    logic       load;       // shift one byte into the block window
    logic [7:0] load_byte;
  } comp_ctl_t;

  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARKER  = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/sha256_compress.sv =====
`default_nettype none

// One SHA-256 round per cycle on a shared round unit. The 512-bit block
// window doubles as the byte loader and the 16-word message schedule.
module sha256_compress (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha256_pkg::comp_ctl_t ctl,
  output logic                       done,
  output sha256_pkg::hash_t          hash
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_ADD   = 2'd2;

  logic [1:0]        cstate;
  logic [5:0]        round;
  logic [511:0]      sched;
  sha256_pkg::hash_t v;
  sha256_pkg::hash_t v_next;
  logic [31:0]       w_cur;
  logic [31:0]       w_new;
  logic [31:0]       t1;
  logic [31:0]       t2;

  // Word j of the window sits at sched[511-32*j -: 32]; word 0 is w[i].
  assign w_cur = sched[511:480];
  assign w_new = sha256_pkg::ssig1(sched[63:32]) + sched[223:192] +
                 sha256_pkg::ssig0(sched[479:448]) + w_cur;

  assign t1 = v[7] + sha256_pkg::bsig1(v[4]) + sha256_pkg::ch(v[4], v[5], v[6]) +
              sha256_pkg::round_k(round) + w_cur;
  assign t2 = sha256_pkg::bsig0(v[0]) + sha256_pkg::maj(v[0], v[1], v[2]);

  always_comb begin
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

  assign done = (cstate == C_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      round  <= '0;
      hash   <= sha256_pkg::H_INIT;
    end else begin
      unique case (cstate)
        C_IDLE: begin
          if (ctl.start) begin
            cstate <= C_ROUND;
            round  <= '0;
          end
        end
        C_ROUND: begin
          round <= round + 6'd1;
          if (round == sha256_pkg::LAST_ROUND) begin
            cstate <= C_ADD;
          end
        end
        C_ADD: begin
          cstate <= C_IDLE;
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
        end
        default: cstate <= C_IDLE;
      endcase
      if (ctl.init) begin
        hash <= sha256_pkg::H_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cstate == C_IDLE && ctl.start) begin
      v <= hash;
    end else if (cstate == C_ROUND) begin
      v <= v_next;
    end
    if (ctl.load) begin
      sched <= {sched[503:0], ctl.load_byte};
    end else if (cstate == C_ROUND) begin
      sched <= {sched[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

// ===== src/sha256_byte_stream_hasher_top.sv =====
// SHA-256 hasher over a byte stream.
// Input channel (s_*): one transfer carries an optional message byte in
// s_tdata, a flag in s_tuser saying the byte belongs to the message, and
// s_tlast to close the message after that byte. A transfer with neither
// flag set is dropped. Output channel (m_*): after a closed message the
// block sends eight transfers, digest word 0 (most significant) first,
// with the word position in m_tuser and m_tlast on the eighth word.
// Message bytes are taken without pause until every 64th byte starts the
// compression, which runs one round per cycle on a single round unit;
// s_tready stays low until it is finished. Closing a message feeds the
// padding bytes (marker, zero fill to byte 56, eight length bytes) one
// per cycle, except while a compression runs and in the step from the
// zero fill to the length bytes; this takes one or two compressions, and
// the first digest word follows the last of them.
// The block takes no input while it compresses, pads or sends the digest.
// If the receiver stalls, the current word is held on m_* unchanged. After
// the eighth word is taken the block returns to the initial hash state.
// Reset (rst, synchronous) restores the initial hash values, clears the
// byte and length counters and drops any message in progress.
`default_nettype none

module sha256_byte_stream_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] has_byte
  input  wire logic        s_tlast,   // end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] digest_word
  output logic [2:0]       m_tuser,   // [2:0] word_index
  output logic             m_tlast    // last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_LEN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [2:0]            resume;
  logic [2:0]            resume_next;
  logic [5:0]            count;
  logic [60:0]           msg_len;
  logic [2:0]            len_idx;
  logic [2:0]            out_idx;
  logic                  push_en;
  logic [7:0]            push_byte;
  logic [63:0]           len_bits;
  logic                  in_xfer;
  logic                  out_xfer;
  logic                  out_done;
  logic                  comp_done;
  sha256_pkg::comp_ctl_t ctl;
  sha256_pkg::hash_t     hash;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign out_done = out_xfer && (out_idx == sha256_pkg::LAST_WORD);
  assign len_bits = {msg_len, 3'b000};

  // Every byte of the block, message or padding, goes through one push path.
  // The push that fills the block also starts the compression, and the
  // sequencer parks in S_COMP until the round unit is finished.
  always_comb begin
    push_en     = 1'b0;
    push_byte   = 8'h00;
    state_next  = state;
    resume_next = resume;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser) begin
            push_en   = 1'b1;
            push_byte = s_tdata;
          end
          state_next = s_tlast ? S_MARK : S_IDLE;
        end
      end
      S_MARK: begin
        push_en    = 1'b1;
        push_byte  = sha256_pkg::PAD_MARKER;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        if (count == sha256_pkg::LEN_POS) begin
          state_next = S_LEN;
        end else begin
          push_en = 1'b1;
        end
      end
      S_LEN: begin
        // Length goes out most significant byte first.
        push_en    = 1'b1;
        push_byte  = len_bits[{~len_idx, 3'b000} +: 8];
        state_next = S_LEN;
      end
      S_COMP: begin
        if (comp_done) begin
          state_next = resume;
        end
      end
      S_OUT: begin
        if (out_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (push_en && count == sha256_pkg::LAST_BYTE) begin
      resume_next = state_next;
      state_next  = S_COMP;
    end
  end

  // The eighth length byte always completes the block, so after that
  // compression the sequencer resumes in S_OUT.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      resume  <= S_IDLE;
      count   <= '0;
      msg_len <= '0;
      len_idx <= '0;
      out_idx <= '0;
    end else begin
      state  <= (state == S_LEN && len_idx == sha256_pkg::LAST_WORD) ? S_COMP : state_next;
      resume <= (state == S_LEN && len_idx == sha256_pkg::LAST_WORD) ? S_OUT : resume_next;
      if (push_en) begin
        count <= count + 6'd1;
      end
      if (in_xfer && s_tuser) begin
        msg_len <= msg_len + 61'd1;
      end
      if (state == S_LEN) begin
        len_idx <= len_idx + 3'd1;
      end
      if (out_xfer) begin
        out_idx <= out_idx + 3'd1;
      end
      if (out_done) begin
        msg_len <= '0;
      end
    end
  end

  assign ctl.start     = push_en && (count == sha256_pkg::LAST_BYTE);
  assign ctl.init      = out_done;
  assign ctl.load      = push_en;
  assign ctl.load_byte = push_byte;

  sha256_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .done (comp_done),
    .hash (hash)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = hash[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == sha256_pkg::LAST_WORD);

endmodule

`default_nettype wire

// ===== src/sha256_hasher_chk.sv =====
`default_nettype none

module sha256_hasher_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  // After reset the block waits for input and sends nothing.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("block not idle after reset");

  // The digest is never sent while input is taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while digest pending");

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("digest word changed under stall");

  // Words follow each other in order without gaps until the last one.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tuser == 3'($past(m_tuser) + 3'd1)))
    else $error("digest word sequence broken");

  // Only the eighth word is marked last.
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
    else $error("last mark on wrong word");

endmodule

bind sha256_byte_stream_hasher_top sha256_hasher_chk u_chk (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

// Self-checking bench for the SHA-256 byte stream hasher.
// A behavioral SHA-256 built into this module follows every accepted input
// transfer and queues the eight digest words that a closed message must
// produce. A monitor compares each output transfer with the oldest queued
// word. Both sides insert random idle bursts, except in the last test,
// where the stream runs with no gaps at all.
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 220;
  localparam int unsigned RANDOM_ITEM_BUDGET = 20;

  // Round constants and initial hash values of SHA-256, index 0 first.
  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] SHA_H0 = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LENGTH_FIELD_POS = 56;

  // One digest word as it should appear on the output channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // All block inputs start at known values.
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       s_tuser = 1'b0;    // [0] has_byte
  logic       s_tlast = 1'b0;    // end_of_message
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [31:0] digest_word
  logic [2:0]  m_tuser;          // [2:0] word_index
  logic        m_tlast;          // last_word

  // Shadow state of the hash engine.
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [60:0] message_bytes;

  digest_beat_t pending_digest[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned message_items = 0;
  int unsigned sink_stall_left = 0;
  bit          source_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  sha256_byte_stream_hasher_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------
  // Behavioral SHA-256 that follows the accepted input stream.
  // ------------------------------------------------------------------

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic clear_hash_state();
    for (int i = 0; i < 8; i++) begin
      hash_state[i] = SHA_H0[i];
    end
    for (int i = 0; i < 64; i++) begin
      block_bytes[i] = 8'h00;
    end
    block_fill = 0;
    message_bytes = '0;
  endtask

  // Runs the 64 rounds on the current block and folds them into the hash.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
              block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i - 15], 7) ^ rotr32(w[i - 15], 18) ^ (w[i - 15] >> 3);
      s1 = rotr32(w[i - 2], 17) ^ rotr32(w[i - 2], 19) ^ (w[i - 2] >> 10);
      w[i] = w[i - 16] + s0 + w[i - 7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) +
           ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) +
           ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  // Applies one accepted input transfer. A closing transfer pads the
  // message, queues the eight digest words and returns to the start state.
  task automatic absorb_transfer(input logic [7:0] data_byte, input bit has_byte,
                                 input bit end_of_message);
    logic [63:0] bit_length;
    if (has_byte) begin
      block_bytes[block_fill] = data_byte;
      block_fill++;
      message_bytes = message_bytes + 61'd1;
      // A full block is compressed right away, so the fill never rests at 64.
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (end_of_message) begin
      block_bytes[block_fill] = PAD_BYTE;
      block_fill++;
      // No room left for the length field: pad this block out and start another.
      if (block_fill > LENGTH_FIELD_POS) begin
        for (int i = block_fill; i < 64; i++) begin
          block_bytes[i] = 8'h00;
        end
        compress_block();
        block_fill = 0;
      end
      for (int i = block_fill; i < LENGTH_FIELD_POS; i++) begin
        block_bytes[i] = 8'h00;
      end
      bit_length = {message_bytes, 3'b000};
      for (int i = 0; i < 8; i++) begin
        block_bytes[LENGTH_FIELD_POS + i] = bit_length[63 - 8 * i -: 8];
      end
      compress_block();
      for (int i = 0; i < 8; i++) begin
        pending_digest.push_back('{word: hash_state[i], index: i[2:0], last: (i == 7)});
      end
      clear_hash_state();
    end
  endtask

  // ------------------------------------------------------------------
  // Input side: one transfer at a time, with optional idle bursts before it.
  // Valid stays high from one transfer to the next unless a gap is drawn.
  // ------------------------------------------------------------------

  task automatic send_transfer(input logic [7:0] data_byte, input bit has_byte,
                               input bit end_of_message);
    if (source_gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data_byte;
    s_tuser  <= has_byte;
    s_tlast  <= end_of_message;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_transfer(data_byte, has_byte, end_of_message);
    if (has_byte || end_of_message) begin
      message_items++;
    end
  endtask

  // Sends a message of random bytes. With noise on, ignored transfers
  // (no byte, no end mark, random data) are scattered through it. The end
  // mark either rides on the last byte or follows as a transfer of its own.
  task automatic send_message(input int unsigned length, input bit separate_end,
                              input bit noise);
    for (int unsigned i = 0; i < length; i++) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        send_transfer(8'($urandom), 1'b0, 1'b0);
      end
      send_transfer(8'($urandom), 1'b1, !separate_end && (i == length - 1));
    end
    if (separate_end || length == 0) begin
      send_transfer(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // ------------------------------------------------------------------
  // Output side: random back-pressure and the digest word checker.
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    if (sink_stall_left > 0) begin
      m_tready <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      sink_stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest transfer: data %h index %0d last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        error_count++;
      end else begin
        want = pending_digest.pop_front();
        if (m_tdata !== want.word) begin
          $display("%0t: digest_word mismatch: expected %h actual %h",
                   $time, want.word, m_tdata);
          error_count++;
        end
        if (m_tuser !== want.index) begin
          $display("%0t: word_index mismatch: expected %0d actual %0d",
                   $time, want.index, m_tuser);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last_word mismatch: expected %b actual %b",
                   $time, want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Short hand-picked cases: the empty message, a classic three-byte
  // message with an ignored transfer in the middle, the extreme byte
  // values, an end mark on its own after a byte, and two empty messages
  // back to back.
  task automatic test_directed_cases();
    send_transfer(8'hff, 1'b0, 1'b0);
    send_transfer(8'h00, 1'b0, 1'b1);
    send_transfer(8'h61, 1'b1, 1'b0);
    send_transfer(8'h5a, 1'b0, 1'b0);
    send_transfer(8'h62, 1'b1, 1'b0);
    send_transfer(8'h63, 1'b1, 1'b1);
    send_transfer(8'hff, 1'b1, 1'b0);
    send_transfer(8'hff, 1'b0, 1'b1);
    send_transfer(8'h00, 1'b1, 1'b1);
    send_transfer(8'h00, 1'b0, 1'b0);
    send_transfer(8'hff, 1'b0, 1'b1);
    send_transfer(8'h3c, 1'b0, 1'b1);
    send_transfer(8'h80, 1'b1, 1'b0);
    send_transfer(8'h7f, 1'b1, 1'b1);
  endtask

  // Lengths at the padding and block edges: 56 bytes leave no room for
  // the length after the marker, so the padding spills into a second
  // block; 64 bytes fill a block exactly, with the end mark on the last
  // byte, so padding starts in a fresh block.
  task automatic test_block_boundaries();
    send_message(56, 1'b1, 1'b0);
    send_message(64, 1'b0, 1'b0);
  endtask

  // Random messages, mostly very short so that digests come often, with
  // an occasional slightly longer one mixed in.
  task automatic test_random_messages();
    int unsigned start_items;
    int unsigned length;
    start_items = message_items;
    while (message_items - start_items < RANDOM_ITEM_BUDGET) begin
      case ($urandom_range(0, 9))
        8, 9:    length = $urandom_range(9, 16);
        default: length = $urandom_range(0, 8);
      endcase
      send_message(length, 1'($urandom), 1'($urandom));
    end
  endtask

  // Both sides at full rate to the end of the run.
  task automatic test_full_rate();
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    send_message($urandom_range(1, 8), 1'b0, 1'b0);
    send_message(0, 1'b1, 1'b0);
    send_message($urandom_range(1, 8), 1'b1, 1'b0);
  endtask

  initial begin
    clear_hash_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_block_boundaries();
    test_random_messages();
    test_full_rate();

    s_tvalid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    // Any digest transfer still in flight would show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
